// ===== sv/bchd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// Types and constants for the button click/hold detector: beat payloads,
// configuration register indexes, reset values and click count limits.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int unsigned ID_W    = 2;
  localparam int unsigned TIME_W  = 10;
  localparam int unsigned TIMER_W = 11;
  localparam int unsigned CLICK_W = 7;
  localparam int unsigned STAT_W  = 10;

  localparam logic [CLICK_W-1:0] CLICK_CAP = 7'd100;
  localparam logic [CLICK_W-1:0] CLICK_SAT = 7'd101;

  localparam logic [TIME_W-1:0] HOLD_TIME_RST  = 10'd20;
  localparam logic [TIME_W-1:0] CLICK_TIME_RST = 10'd2;

  typedef enum logic [0:0] {
    REG_HOLD_TIME  = 1'b0,
    REG_CLICK_TIME = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0] button_index;
    logic            pressed;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    button_id;
    logic               is_on;
    logic               hold_event;
    logic               sequence_done;
    logic [CLICK_W-1:0] click_total;
    logic               status_changed;
  } out_item_t;

endpackage

// ===== sv/button_click_hold_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Per-button multi-click and long-press detector, one poll sample per beat.
//
// Usage:
//   in_valid/in_stall/in_data carry one poll sample (button_index, pressed).
//   out_valid/out_stall/out_data carry one status beat for every sample, in
//   order: is_on, hold_event, sequence_done, click_total (capped at 100) and
//   status_changed against the last status reported for that button.
//   cfg_we/cfg_index/cfg_data write hold_time (index 0) and click_time
//   (index 1); write them only while no sample is in flight.
//   Accepted samples pass through the input register, then the output register.
//   Throughput is one sample per cycle while the output is not stalled, also
//   for the same button on consecutive cycles: the per-button timers are read,
//   updated and written back in the one compute stage between those registers.
//   A sample whose button_index is at or above BUTTON_COUNT changes no state
//   and returns a status beat with only button_id set.
//   Reset clears all timers, click counts and last statuses, and loads
//   hold_time 20 and click_time 2.
//   While out_stall holds a full output register, the input register stays
//   full and in_stall rises; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module button_click_hold_detector
  import bchd_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_index,
  input  logic [TIME_W-1:0] cfg_data
);

  logic [TIME_W-1:0]  hold_time_r;
  logic [TIME_W-1:0]  click_time_r;

  logic [TIMER_W-1:0] press_timer_r   [BUTTON_COUNT];
  logic [TIMER_W-1:0] release_timer_r [BUTTON_COUNT];
  logic [CLICK_W-1:0] click_counter_r [BUTTON_COUNT];
  logic [STAT_W-1:0]  last_reported_r [BUTTON_COUNT];

  logic               s1_valid_r;
  in_item_t           s1_data_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               out_ready;
  logic               s1_move;
  logic               in_take;
  logic               hit;

  logic [TIMER_W-1:0] rd_on;
  logic [TIMER_W-1:0] rd_off;
  logic [CLICK_W-1:0] rd_clicks;
  logic [STAT_W-1:0]  rd_last;

  logic [TIMER_W:0]   h2;
  logic [TIMER_W:0]   on_t;
  logic [TIMER_W:0]   off_t;
  logic [CLICK_W-1:0] clicks;
  logic [CLICK_W-1:0] capped;
  logic               hold;
  logic               done;
  logic [STAT_W-1:0]  status;

  logic [TIMER_W-1:0] on_nxt;
  logic [TIMER_W-1:0] off_nxt;
  logic [CLICK_W-1:0] clicks_nxt;
  out_item_t          out_nxt;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read the addressed button's state
  always_comb begin
    hit       = 1'b0;
    rd_on     = '0;
    rd_off    = '0;
    rd_clicks = '0;
    rd_last   = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (int'(s1_data_r.button_index) == i) begin
        hit       = 1'b1;
        rd_on     = press_timer_r[i];
        rd_off    = release_timer_r[i];
        rd_clicks = click_counter_r[i];
        rd_last   = last_reported_r[i];
      end
    end
  end

  // update timers and click count, build the status
  always_comb begin
    h2     = {1'b0, hold_time_r, 1'b0};
    on_t   = {1'b0, rd_on};
    off_t  = {1'b0, rd_off};
    clicks = rd_clicks;
    hold   = 1'b0;
    done   = 1'b0;
    if (s1_data_r.pressed) begin
      on_t  = (rd_on > rd_off) ? '0 : on_t + 1'b1;
      off_t = off_t + 1'b1;
      if (off_t >= h2) begin
        off_t = h2;
      end
      if (on_t == {2'b00, hold_time_r}) begin
        hold = 1'b1;
      end else if (on_t > {2'b00, hold_time_r}) begin
        clicks = '0;
        on_t   = {2'b00, hold_time_r};
      end else if (on_t == {2'b00, click_time_r}) begin
        if (clicks < CLICK_SAT) begin
          clicks = clicks + 1'b1;
        end
      end
    end else begin
      off_t = (rd_off > rd_on) ? '0 : off_t + 1'b1;
      on_t  = on_t + 1'b1;
      if (on_t >= h2) begin
        on_t = h2;
      end
      if (off_t >= {2'b00, hold_time_r}) begin
        off_t = {2'b00, hold_time_r};
        if (clicks != '0) begin
          done = 1'b1;
        end
      end
    end
    capped = (clicks > CLICK_CAP) ? CLICK_CAP : clicks;
    status = {done, hold, s1_data_r.pressed, capped};
    if (done) begin
      clicks = '0;
    end

    on_nxt     = on_t[TIMER_W-1:0];
    off_nxt    = off_t[TIMER_W-1:0];
    clicks_nxt = clicks;

    out_nxt           = '0;
    out_nxt.button_id = s1_data_r.button_index;
    if (hit) begin
      out_nxt.is_on          = s1_data_r.pressed;
      out_nxt.hold_event     = hold;
      out_nxt.sequence_done  = done;
      out_nxt.click_total    = capped;
      out_nxt.status_changed = (status != rd_last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r  <= HOLD_TIME_RST;
      click_time_r <= CLICK_TIME_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        press_timer_r[i]   <= '0;
        release_timer_r[i] <= '0;
        click_counter_r[i] <= '0;
        last_reported_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOLD_TIME:  hold_time_r  <= cfg_data;
          REG_CLICK_TIME: click_time_r <= cfg_data;
          default: ;
        endcase
      end

      // hold the input register while the output is stalled
      if (in_take) begin
        s1_valid_r <= 1'b1;
        s1_data_r  <= in_data;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end

      // advance the output register
      if (s1_move) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // write back the addressed button's state
      if (s1_move) begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
          if (int'(s1_data_r.button_index) == i) begin
            press_timer_r[i]   <= on_nxt;
            release_timer_r[i] <= off_nxt;
            click_counter_r[i] <= clicks_nxt;
            last_reported_r[i] <= status;
          end
        end
      end
    end
  end

endmodule

// ===== dv/button_click_hold_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector_test
// Self-checking bench for the click/hold detector. A short table of poll
// samples runs first, then random click trains, long presses and noise are
// played under several hold/click timings, with random gaps on both sides.
// Every status beat is checked in order: typed table rows against their listed
// beat, others against a cycle-free model of button timers, click counts, last status.
// ----------------------------------------------------------------------------
module button_click_hold_detector_test;
  import bchd_pkg::*;

  localparam int unsigned BUTTONS  = 4;
  localparam int unsigned PHASES   = 8;
  localparam int unsigned RUN_CAP  = 60;
  localparam int unsigned SHOW_MAX = 10;

  localparam int unsigned PH_HOLD  [PHASES] = '{20, 10, 2, 5, 4, 1023, 1, 0};
  localparam int unsigned PH_CLICK [PHASES] = '{2, 1, 1, 5, 9, 1022, 0, 3};
  localparam int unsigned PH_ITEMS [PHASES] = '{100, 420, 80, 90, 60, 80, 60, 40};

  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_SEND = 2'd1,
    IDLE_RECV = 2'd2,
    IDLE_BOTH = 2'd3
  } idle_mode_t;

  typedef struct {
    in_item_t    beat;
    int unsigned reps;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [TIME_W-1:0] cfg_data;

  logic [TIME_W-1:0]  hold_cfg;
  logic [TIME_W-1:0]  click_cfg;
  logic [TIMER_W-1:0] press_tmr   [BUTTONS];
  logic [TIMER_W-1:0] release_tmr [BUTTONS];
  logic [CLICK_W-1:0] click_cnt   [BUTTONS];
  logic [STAT_W-1:0]  last_stat   [BUTTONS];

  out_item_t   pending_status [$];
  idle_mode_t  mode;
  int unsigned beats_in;
  int unsigned status_beats;
  int unsigned bad_beats;

  dir_row_t plan [7] = '{
    '{'{2'd0, 1'b0}, 1, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0}},
    '{'{2'd3, 1'b1}, 1, 1'b1, '{2'd3, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1}},
    '{'{2'd3, 1'b1}, 1, 1'b1, '{2'd3, 1'b1, 1'b0, 1'b0, 7'd1, 1'b1}},
    '{'{2'd3, 1'b1}, 1, 1'b1, '{2'd3, 1'b1, 1'b0, 1'b0, 7'd1, 1'b0}},
    '{'{2'd3, 1'b0}, 18, 1'b0, '{2'd0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0}},
    '{'{2'd2, 1'b1}, 1, 1'b1, '{2'd2, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1}},
    '{'{2'd2, 1'b0}, 1, 1'b1, '{2'd2, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1}}
  };

  button_click_hold_detector #(
    .BUTTON_COUNT(BUTTONS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit idle_roll(input bit sender_side);
    bit hit;
    hit = 1'b0;
    case (mode)
      IDLE_SEND: if (sender_side) hit = ($urandom_range(0, 99) < 51);
      IDLE_RECV: if (!sender_side) hit = ($urandom_range(0, 99) < 51);
      IDLE_BOTH: hit = ($urandom_range(0, 99) < 34);
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic out_item_t predict_status(input in_item_t s);
    int unsigned b, on_t, off_t, clicks, h, h2, capped;
    logic hold, done;
    logic [STAT_W-1:0] stat;
    out_item_t r;
    r = '0;
    r.button_id = s.button_index;
    b = s.button_index;
    if (b >= BUTTONS) return r;
    h = hold_cfg;
    h2 = 2 * h;
    on_t = press_tmr[b];
    off_t = release_tmr[b];
    clicks = click_cnt[b];
    hold = 1'b0;
    done = 1'b0;
    if (s.pressed) begin
      on_t = (on_t > off_t) ? 0 : on_t + 1;
      off_t = (off_t + 1 >= h2) ? h2 : off_t + 1;
      if (on_t == h) begin
        hold = 1'b1;
      end else if (on_t > h) begin
        clicks = 0;
        on_t = h;
      end else if (on_t == click_cfg) begin
        if (clicks < CLICK_SAT) clicks++;
      end
    end else begin
      off_t = (off_t > on_t) ? 0 : off_t + 1;
      on_t = (on_t + 1 >= h2) ? h2 : on_t + 1;
      if (off_t >= h) begin
        off_t = h;
        done = (clicks > 0);
      end
    end
    capped = (clicks > CLICK_CAP) ? CLICK_CAP : clicks;
    stat = {done, hold, s.pressed, capped[CLICK_W-1:0]};
    if (done) clicks = 0;
    r.is_on = s.pressed;
    r.hold_event = hold;
    r.sequence_done = done;
    r.click_total = capped[CLICK_W-1:0];
    r.status_changed = (stat != last_stat[b]);
    last_stat[b] = stat;
    press_tmr[b] = on_t[TIMER_W-1:0];
    release_tmr[b] = off_t[TIMER_W-1:0];
    click_cnt[b] = clicks[CLICK_W-1:0];
    return r;
  endfunction

  // enter and leave at a falling edge
  task automatic send_beat(input in_item_t s, input bit typed, input out_item_t want);
    out_item_t p;
    while (idle_roll(1'b1)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_status(s);
    pending_status.push_back(typed ? want : p);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  task automatic program_timing(input int unsigned h, input int unsigned c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HOLD_TIME;
    cfg_data  <= h[TIME_W-1:0];
    @(negedge clk);
    cfg_index <= REG_CLICK_TIME;
    cfg_data  <= c[TIME_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    hold_cfg  = h[TIME_W-1:0];
    click_cfg = c[TIME_W-1:0];
  endtask

  task automatic run_level(input logic [ID_W-1:0] b, input logic lvl, input int unsigned n);
    in_item_t s;
    int unsigned k;
    s.button_index = b;
    s.pressed = lvl;
    for (k = 0; k < n && k < RUN_CAP; k++) send_beat(s, 1'b0, '0);
  endtask

  task automatic play_train(input logic [ID_W-1:0] b, input int unsigned n, input bit steady);
    int unsigned i, pr;
    for (i = 0; i < n; i++) begin
      pr = click_cfg + 1;
      if (!steady && $urandom_range(0, 3) == 0) pr = $urandom_range(1, click_cfg + 3);
      run_level(b, 1'b1, pr);
      run_level(b, 1'b0, steady ? 1 : $urandom_range(1, 2));
    end
    if (!steady && $urandom_range(0, 4) == 0) run_level(b, 1'b0, $urandom_range(0, hold_cfg));
    else run_level(b, 1'b0, hold_cfg + $urandom_range(0, 2));
  endtask

  task automatic play_burst();
    logic [ID_W-1:0] b;
    int unsigned pick, n;
    b = ID_W'($urandom_range(0, BUTTONS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) send_beat(in_item_t'(3'($urandom_range(0, 7))), 1'b0, '0);
    end else if (pick < 25) begin
      run_level(b, 1'b1, hold_cfg + $urandom_range(0, 3));
      run_level(b, 1'b0, $urandom_range(0, hold_cfg + 2));
    end else begin
      play_train(b, $urandom_range(1, 4), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_beats++;
      if (pending_status.size() == 0) begin
        bad_beats++;
        if (bad_beats <= SHOW_MAX) $display("unexpected status beat %0d", status_beats);
      end else begin
        want = pending_status.pop_front();
        if (out_data.button_id !== want.button_id || out_data.is_on !== want.is_on ||
            out_data.hold_event !== want.hold_event ||
            out_data.sequence_done !== want.sequence_done ||
            out_data.click_total !== want.click_total ||
            out_data.status_changed !== want.status_changed) begin
          bad_beats++;
          if (bad_beats <= SHOW_MAX)
            $display("status beat %0d mismatch: want id=%0d on=%0d hold=%0d done=%0d",
                     status_beats, want.button_id, want.is_on, want.hold_event,
                     want.sequence_done,
                     " clicks=%0d chg=%0d, got id=%0d on=%0d hold=%0d done=%0d",
                     want.click_total, want.status_changed,
                     out_data.button_id, out_data.is_on, out_data.hold_event,
                     out_data.sequence_done,
                     " clicks=%0d chg=%0d", out_data.click_total,
                     out_data.status_changed);
        end
      end
    end
  end

  // hold off once for a long stretch so the input side backs up
  initial begin
    int unsigned hold_left;
    bit held_long;
    hold_left = 0;
    held_long = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_long && status_beats >= 300) begin
        held_long = 1'b1;
        hold_left = 59;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_roll(1'b0);
      end
    end
  end

  initial begin
    int unsigned ph, goal, i, k;
    bit paused;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_HOLD_TIME;
    cfg_data  <= '0;
    mode = IDLE_NONE;
    beats_in = 0;
    status_beats = 0;
    bad_beats = 0;
    hold_cfg = HOLD_TIME_RST;
    click_cfg = CLICK_TIME_RST;
    for (i = 0; i < BUTTONS; i++) begin
      press_tmr[i] = '0;
      release_tmr[i] = '0;
      click_cnt[i] = '0;
      last_stat[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        program_timing(PH_HOLD[ph], PH_CLICK[ph]);
      end
      mode = idle_mode_t'(ph % 4);
      goal = beats_in + PH_ITEMS[ph];
      paused = 1'b0;
      if (ph == 0) begin
        for (i = 0; i < $size(plan); i++)
          for (k = 0; k < plan[i].reps; k++) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
      if (ph == 1) play_train(2'd1, 106, 1'b1);
      while (beats_in < goal) begin
        play_burst();
        if (ph == 3 && !paused && beats_in + PH_ITEMS[ph] / 2 >= goal) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (5) @(negedge clk);
    if (bad_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== button_click_hold_detector.f =====
sv/bchd_pkg.sv
sv/button_click_hold_detector.sv
dv/button_click_hold_detector_test.sv
